[hdl/phase_residue_detector_core_assert.svh]
// ----------------------------------------------------------------------------
// phase_residue_detector_core_assert
// Assertion helpers shared by the residue detector modules.
// ----------------------------------------------------------------------------
// Each macro expects signals named clk and arst_n in the using module.
`ifndef PHASE_RESIDUE_DETECTOR_CORE_ASSERT_SVH
`define PHASE_RESIDUE_DETECTOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/prd_pkg.sv]
// ----------------------------------------------------------------------------
// prd_pkg
// Shared types and constants of the phase residue detector.
// ----------------------------------------------------------------------------
`default_nettype none

package prd_pkg;

	// Result classification of one 2x2 square.
	typedef enum logic [1:0] {
		RES_NONE = 2'd0,
		RES_POS  = 2'd1,
		RES_NEG  = 2'd2,
		RES_SKIP = 2'd3
	} residue_code_t;

	// Register indexes on the configuration port.
	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_index_t;

	localparam int unsigned CFG_BITS      = 13;
	localparam int unsigned POS_BITS      = 12;
	localparam int unsigned COUNT_BITS    = 24;
	localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 13'd1024;
	localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 13'd1024;
	localparam logic [CFG_BITS-1:0] DIM_MIN      = 13'd2;
	localparam logic [CFG_BITS-1:0] HEIGHT_MAX   = 13'd4096;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX  = 24'hFF_FFFF;

	// Position and end marker that travel with a square.
	typedef struct packed {
		logic [POS_BITS-1:0] col;
		logic [POS_BITS-1:0] row;
		logic                last;
	} square_tag_t;

endpackage

`default_nettype wire

[hdl/phase_residue_detector_core.sv]
// ----------------------------------------------------------------------------
// phase_residue_detector_core
// Raster-stream 2x2 phase residue detector with a one-row line buffer.
// ----------------------------------------------------------------------------
// Pixels enter on the pixel channel (pixel_valid / pixel_stall) in raster
// order, one word per pixel: a wrapped phase and an avoid flag. Each pixel in
// column one or later of row one or later closes a 2x2 square, and one word
// leaves on the square channel (square_valid / square_stall) with the square's
// upper-left position, its residue code, the running residue count of the
// image and a flag on the final square. Pixels of row zero or column zero
// produce no word.
// The block takes one pixel per cycle while pixel_stall is low. A word is
// presented after its pixel is accepted: the line buffer read and the pixel
// registers fill on the accepting edge, and the loop sum is evaluated into
// the output register when that register can take a word. The line buffer is
// a single-port memory that returns the old entry of a column while the new
// pixel overwrites it, so no two accesses ever collide.
// When the receiver stalls, the output register holds its word, the pixel
// stage holds one more item, and only then is pixel_stall raised.
// Reset clears the counters, the residue count and the valid flags and loads
// a 1024 by 1024 image size; the line buffer is not cleared, since every entry
// is written in row zero before it is read. The user writes image width and
// height over the APB port only while the block idles; it is not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

`include "phase_residue_detector_core_assert.svh"

module phase_residue_detector_core #(
	parameter int unsigned MAX_WIDTH  = 4096,
	parameter int unsigned PHASE_BITS = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// Configuration port.
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [2:0]              paddr,
	input  wire logic [31:0]             pwdata,
	output logic      [31:0]             prdata,
	output logic                         pready,
	// Pixel channel.
	input  wire logic                    pixel_valid,
	output logic                         pixel_stall,
	input  wire logic [PHASE_BITS-1:0]   phase_sample,
	input  wire logic                    avoid_pixel,
	// Square channel.
	output logic                         square_valid,
	input  wire logic                    square_stall,
	output logic [prd_pkg::POS_BITS-1:0] square_column,
	output logic [prd_pkg::POS_BITS-1:0] square_row,
	output logic [1:0]                   residue_code,
	output logic [prd_pkg::COUNT_BITS-1:0] residue_total,
	output logic                         last_square
);

	// Column counter and line buffer address width.
	localparam int unsigned CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned PW  = PHASE_BITS + 1;
	localparam int unsigned EXT = CW + prd_pkg::POS_BITS;

	logic [CW-1:0]                   last_col;
	logic [prd_pkg::POS_BITS-1:0]    last_row;

	logic [CW-1:0]                   col_q;
	logic [prd_pkg::POS_BITS-1:0]    row_q;
	logic                            pixel_accept;
	logic                            end_row;
	logic                            end_image;
	logic [PW-1:0]                   cur;
	logic [PW-1:0]                   up_rd;
	logic [CW-1:0]                   col_m1;
	logic [EXT-1:0]                  col_ext;

	// Pixel stage: the new lower-right pixel, its left neighbor and the
	// diagonal entry read for the previous pixel.
	logic                            valid_s1;
	logic                            has_sq_s1;
	logic [PW-1:0]                   lr_s1;
	logic [PW-1:0]                   ll_s1;
	logic [PW-1:0]                   ul_s1;
	prd_pkg::square_tag_t            tag_s1;
	logic                            eval_take;

	prd_regs #(
		.MAX_WIDTH (MAX_WIDTH),
		.CW        (CW)
	) u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.last_col (last_col),
		.last_row (last_row)
	);

	assign pixel_stall  = valid_s1 && !eval_take;
	assign pixel_accept = pixel_valid && !pixel_stall;

	assign cur       = {avoid_pixel, phase_sample};
	assign end_row   = col_q >= last_col;
	assign end_image = end_row && (row_q >= last_row);

	// Square position is one column and one row up-left of the new pixel.
	assign col_m1  = col_q - CW'(1);
	assign col_ext = EXT'(col_m1);

	prd_line_buf #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW),
		.DW    (PW)
	) u_line_buf (
		.clk   (clk),
		.en    (pixel_accept),
		.addr  (col_q),
		.wdata (cur),
		.rdata (up_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (pixel_accept) begin
				valid_s1 <= 1'b1;
				if (end_row) begin
					col_q <= '0;
					row_q <= end_image ? '0 : row_q + prd_pkg::POS_BITS'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end else if (eval_take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// The previous pixel's read data and value become the diagonal and left
	// corners before the stage registers are overwritten.
	always_ff @(posedge clk) begin
		if (pixel_accept) begin
			has_sq_s1   <= (col_q != '0) && (row_q != '0);
			lr_s1       <= cur;
			ll_s1       <= lr_s1;
			ul_s1       <= up_rd;
			tag_s1.col  <= col_ext[prd_pkg::POS_BITS-1:0];
			tag_s1.row  <= row_q - prd_pkg::POS_BITS'(1);
			tag_s1.last <= end_image;
		end
	end

	prd_square_eval #(
		.PHASE_BITS (PHASE_BITS)
	) u_eval (
		.clk           (clk),
		.arst_n        (arst_n),
		.sq_valid      (valid_s1 && has_sq_s1),
		.tag           (tag_s1),
		.ul            (ul_s1),
		.ur            (up_rd),
		.ll            (ll_s1),
		.lr            (lr_s1),
		.take          (eval_take),
		.square_valid  (square_valid),
		.square_stall  (square_stall),
		.square_column (square_column),
		.square_row    (square_row),
		.residue_code  (residue_code),
		.residue_total (residue_total),
		.last_square   (last_square)
	);

	`PRD_ASSERT_NEXT(a_row_end_wraps_column, pixel_accept && end_row, col_q == '0, "column did not wrap at end of row")
	`PRD_ASSERT_SAME(a_stall_needs_full_stage, pixel_stall, valid_s1 && square_valid && square_stall, "pixel stall without a blocked pipeline")
	`PRD_ASSERT_NEXT(a_image_end_resets_row, pixel_accept && end_image, row_q == '0, "row did not restart after last square")

endmodule

`default_nettype wire

[hdl/prd_regs.sv]
// ----------------------------------------------------------------------------
// prd_regs
// Configuration registers behind the APB port, with clamped image limits.
// ----------------------------------------------------------------------------
`default_nettype none

module prd_regs #(
	parameter int unsigned MAX_WIDTH = 4096,
	parameter int unsigned CW        = 12
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [2:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic      [31:0]   prdata,
	output logic               pready,
	output logic      [CW-1:0] last_col,
	output logic      [prd_pkg::POS_BITS-1:0] last_row
);

	localparam int unsigned WC = (CW + 1 > prd_pkg::CFG_BITS) ? CW + 1 : prd_pkg::CFG_BITS;

	logic [prd_pkg::CFG_BITS-1:0] width_q;
	logic [prd_pkg::CFG_BITS-1:0] height_q;
	logic                         wr_en;
	prd_pkg::reg_index_t          idx;
	logic [WC-1:0]                w_ext;
	logic [WC-1:0]                w_eff;
	logic [prd_pkg::CFG_BITS-1:0] h_eff;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = prd_pkg::reg_index_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= prd_pkg::WIDTH_RESET;
			height_q <= prd_pkg::HEIGHT_RESET;
		end else if (wr_en) begin
			unique case (idx)
				prd_pkg::REG_IMAGE_WIDTH:  width_q  <= pwdata[prd_pkg::CFG_BITS-1:0];
				prd_pkg::REG_IMAGE_HEIGHT: height_q <= pwdata[prd_pkg::CFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			prd_pkg::REG_IMAGE_WIDTH:  prdata = 32'(width_q);
			prd_pkg::REG_IMAGE_HEIGHT: prdata = 32'(height_q);
			default:                   prdata = '0;
		endcase
	end

	// Clamp the programmed sizes to the supported range.
	always_comb begin
		w_ext = WC'(width_q);
		if (w_ext < WC'(prd_pkg::DIM_MIN)) begin
			w_eff = WC'(prd_pkg::DIM_MIN);
		end else if (w_ext > WC'(MAX_WIDTH)) begin
			w_eff = WC'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		if (height_q < prd_pkg::DIM_MIN) begin
			h_eff = prd_pkg::DIM_MIN;
		end else if (height_q > prd_pkg::HEIGHT_MAX) begin
			h_eff = prd_pkg::HEIGHT_MAX;
		end else begin
			h_eff = height_q;
		end
	end

	assign last_col = CW'(w_eff - WC'(1));
	assign last_row = prd_pkg::POS_BITS'(h_eff - prd_pkg::CFG_BITS'(1));

endmodule

`default_nettype wire

[hdl/prd_line_buf.sv]
// ----------------------------------------------------------------------------
// prd_line_buf
// Previous-row store: one port, read-before-write, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module prd_line_buf #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = 12,
	parameter int unsigned DW    = 17
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [AW-1:0] addr,
	input  wire logic [DW-1:0] wdata,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	// The old entry is returned while the new pixel replaces it.
	always_ff @(posedge clk) begin
		if (en) begin
			rdata_q   <= mem[addr];
			mem[addr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[hdl/prd_square_eval.sv]
// ----------------------------------------------------------------------------
// prd_square_eval
// Loop sum over one 2x2 square, residue count and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "phase_residue_detector_core_assert.svh"

module prd_square_eval #(
	parameter int unsigned PHASE_BITS = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    sq_valid,
	input  wire prd_pkg::square_tag_t    tag,
	input  wire logic [PHASE_BITS:0]     ul,
	input  wire logic [PHASE_BITS:0]     ur,
	input  wire logic [PHASE_BITS:0]     ll,
	input  wire logic [PHASE_BITS:0]     lr,
	output logic                         take,
	output logic                         square_valid,
	input  wire logic                    square_stall,
	output logic [prd_pkg::POS_BITS-1:0] square_column,
	output logic [prd_pkg::POS_BITS-1:0] square_row,
	output logic [1:0]                   residue_code,
	output logic [prd_pkg::COUNT_BITS-1:0] residue_total,
	output logic                         last_square
);

	localparam int unsigned SW = PHASE_BITS + 2;

	function automatic logic signed [SW-1:0] wdiff(input logic [PHASE_BITS-1:0] a,
	                                                input logic [PHASE_BITS-1:0] b);
		logic [PHASE_BITS-1:0] d;
		d = a - b;
		return SW'(signed'(d));
	endfunction

	logic signed [SW-1:0]            loop_sum;
	logic                            any_avoid;
	prd_pkg::residue_code_t          code;
	logic [prd_pkg::COUNT_BITS-1:0]  count_q;
	logic [prd_pkg::COUNT_BITS-1:0]  count_next;
	logic                            load;
	logic                            out_valid_q;
	prd_pkg::square_tag_t            tag_q;
	prd_pkg::residue_code_t          code_q;
	logic [prd_pkg::COUNT_BITS-1:0]  total_q;

	assign any_avoid = ul[PHASE_BITS] | ur[PHASE_BITS] | ll[PHASE_BITS] | lr[PHASE_BITS];
	assign loop_sum  = wdiff(ur[PHASE_BITS-1:0], ul[PHASE_BITS-1:0])
	                 + wdiff(lr[PHASE_BITS-1:0], ur[PHASE_BITS-1:0])
	                 + wdiff(ll[PHASE_BITS-1:0], lr[PHASE_BITS-1:0])
	                 + wdiff(ul[PHASE_BITS-1:0], ll[PHASE_BITS-1:0]);

	always_comb begin
		if (any_avoid) begin
			code = prd_pkg::RES_SKIP;
		end else if (loop_sum > 0) begin
			code = prd_pkg::RES_POS;
		end else if (loop_sum < 0) begin
			code = prd_pkg::RES_NEG;
		end else begin
			code = prd_pkg::RES_NONE;
		end
	end

	// The count saturates rather than wrapping.
	always_comb begin
		count_next = count_q;
		if ((code == prd_pkg::RES_POS || code == prd_pkg::RES_NEG) &&
		    count_q != prd_pkg::COUNT_MAX) begin
			count_next = count_q + prd_pkg::COUNT_BITS'(1);
		end
	end

	assign take = !out_valid_q || !square_stall;
	assign load = take && sq_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (take) begin
				out_valid_q <= sq_valid;
			end
			if (load) begin
				count_q <= tag.last ? '0 : count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tag_q   <= tag;
			code_q  <= code;
			total_q <= count_next;
		end
	end

	assign square_valid  = out_valid_q;
	assign square_column = tag_q.col;
	assign square_row    = tag_q.row;
	assign residue_code  = code_q;
	assign residue_total = total_q;
	assign last_square   = tag_q.last;

	`PRD_ASSERT_NEXT(a_count_cleared_at_end, load && tag.last, count_q == '0, "count not cleared after last square")
	`PRD_ASSERT_NEXT(a_count_kept_no_residue, load && !tag.last && (code == prd_pkg::RES_NONE || code == prd_pkg::RES_SKIP), count_q == $past(count_q), "count moved without a residue")
	`PRD_ASSERT_NEXT(a_word_held_on_stall, square_valid && square_stall, square_valid && $stable(tag_q) && $stable(code_q) && $stable(total_q), "stalled square word changed")

endmodule

`default_nettype wire
